[sv/binary_morphology_3x3_unit_defines.svh]
// Assertion macros shared by the binary morphology RTL.
`ifndef BINARY_MORPHOLOGY_3X3_UNIT_DEFINES_SVH
`define BINARY_MORPHOLOGY_3X3_UNIT_DEFINES_SVH

`ifndef SYNTHESIS
// Same-cycle implication, checked on clk outside of reset.
`define BM3_ASSERT_NOW(label, trig, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (trig) |-> (cons)) else $error(msg);
// Next-cycle implication, checked on clk outside of reset.
`define BM3_ASSERT_NEXT(label, trig, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (trig) |=> (cons)) else $error(msg);
`else
`define BM3_ASSERT_NOW(label, trig, cons, msg)
`define BM3_ASSERT_NEXT(label, trig, cons, msg)
`endif

`endif

[sv/bm3_pkg.sv]
// Shared constants for the binary morphology block.
package bm3_pkg;

  // Field widths.
  localparam int PIXEL_W      = 8;
  localparam int CFG_W        = 11;
  localparam int ROW_W        = 12;
  localparam int OUT_ROW_W    = 11;
  localparam int CFG_ADDR_W   = 4;
  localparam int CFG_DATA_W   = 32;
  localparam int REG_IDX_W    = 2;

  // Default for the line length limit.
  localparam int DEF_MAX_WIDTH = 1024;

  // Register indexes.
  localparam logic [REG_IDX_W-1:0] REG_IMAGE_WIDTH  = 2'd0;
  localparam logic [REG_IDX_W-1:0] REG_IMAGE_HEIGHT = 2'd1;
  localparam logic [REG_IDX_W-1:0] REG_OP_MODE      = 2'd2;

  // Register reset values.
  localparam logic [CFG_W-1:0] IMAGE_WIDTH_RST  = 11'd640;
  localparam logic [CFG_W-1:0] IMAGE_HEIGHT_RST = 11'd480;

  // Operation modes.
  localparam logic MODE_EROSION  = 1'b0;
  localparam logic MODE_DILATION = 1'b1;

  // Item kinds.
  localparam logic FUNC_PIXEL = 1'b0;
  localparam logic FUNC_FLUSH = 1'b1;

  // Only full white counts as a set pixel.
  localparam logic [PIXEL_W-1:0] PIXEL_SET = 8'd255;

endpackage

[sv/bm3_pixel_if.sv]
// Input channel carrying one pixel or flush beat.
interface bm3_pixel_if;
  import bm3_pkg::*;

  logic               valid;
  logic               ready;
  logic               func;
  logic [PIXEL_W-1:0] pixel_value;

  modport source (output valid, output func, output pixel_value, input ready);
  modport sink   (input valid, input func, input pixel_value, output ready);

endinterface

[sv/bm3_result_if.sv]
// Output channel carrying one result pixel beat.
interface bm3_result_if;

  logic valid;
  logic ready;
  logic pixel_on;
  logic frame_end;

  modport source (output valid, output pixel_on, output frame_end, input ready);
  modport sink   (input valid, input pixel_on, input frame_end, output ready);

endinterface

[sv/binary_morphology_3x3_unit.sv]
// Streaming 3x3 binary erosion / dilation with line memory.
//
// Usage: pixels of a raster frame enter on pixel_in, one beat per pixel, line
// by line; a pixel counts as set only when it equals 255. Each result beat on
// result_out carries the erosion or dilation (op_mode) of one position over
// its in-image 3x3 neighbors, and frame_end marks the last one of a frame.
// A result is released by the beat that arrives one line plus one pixel after
// its center; after the last pixel, W+1 flush beats (func = 1) drain the rest.
// Flush beats sent while pixels are still due are taken and ignored.
// Throughput is one beat per cycle unless result_out stalls: both line delays
// share one 2-bit wide line memory that is read when a beat is taken and written
// back as it leaves the memory stage, with a forwarding path for a one-pixel-wide
// frame. A result reaches result_out via the memory stage and the result register.
// Reset clears the counters and window; the line memory is not cleared, its
// stale rows are masked off at the top of each frame.
// When result_out stalls, the result register holds, one more beat can be
// taken into the memory stage, and pixel_in then drops ready.
// Registers (APB, byte address 4*i): image_width, image_height, op_mode;
// write them only between frames.
`include "binary_morphology_3x3_unit_defines.svh"

module binary_morphology_3x3_unit #(
  parameter int MAX_WIDTH = bm3_pkg::DEF_MAX_WIDTH
) (
  input  logic                           clk,
  input  logic                           rst,
  bm3_pixel_if.sink                      pixel_in,
  bm3_result_if.source                   result_out,
  input  logic                           psel,
  input  logic                           penable,
  input  logic                           pwrite,
  input  logic [bm3_pkg::CFG_ADDR_W-1:0] paddr,
  input  logic [bm3_pkg::CFG_DATA_W-1:0] pwdata,
  output logic [bm3_pkg::CFG_DATA_W-1:0] prdata,
  output logic                           pready
);
  import bm3_pkg::*;

  localparam int COL_W = $clog2(MAX_WIDTH);
  localparam int EW    = $clog2(MAX_WIDTH + 1);

  // Configuration registers.
  logic [CFG_W-1:0] image_width;
  logic [CFG_W-1:0] image_height;
  logic             op_mode;

  // Raster position of the next beat and of the next result.
  logic [COL_W-1:0]     in_column, in_column_next;
  logic [ROW_W-1:0]     in_row, in_row_next;
  logic [COL_W-1:0]     out_col, out_col_next;
  logic [OUT_ROW_W-1:0] out_row, out_row_next;

  // Memory stage.
  logic             s1_valid;
  logic             s1_x;
  logic             s1_emit;
  logic             s1_last;
  logic [8:0]       s1_mask;
  logic [COL_W-1:0] s1_col;
  logic             fwd;
  logic [1:0]       fwd_data;
  logic [1:0]       mem_q;
  logic [8:0]       window_bits;

  // Result register.
  logic out_valid;
  logic out_on;
  logic out_end;

  // Line memory: bit 0 delays one line, bit 1 delays two lines.
  logic [1:0] line_mem [MAX_WIDTH];

  logic [31:0]        width_ext;
  logic [31:0]        eff_w_wide;
  logic [EW-1:0]      eff_w;
  logic [CFG_W-1:0]   eff_h;
  logic               accept;
  logic               drop;
  logic               live;
  logic               pixel_phase;
  logic               acc_x;
  logic               acc_emit;
  logic               acc_last;
  logic [8:0]         acc_mask;
  logic               use_left;
  logic               use_right;
  logic               use_above;
  logic               use_below;
  logic               s1_fire;
  logic [1:0]         rd_data;
  logic [1:0]         wr_data;
  logic [8:0]         win_shift;
  logic               win_all;
  logic               win_any;
  logic               cfg_write;

  // Effective frame size: zero counts as one, width clamps to the memory.
  always_comb begin
    width_ext = 32'(image_width);
    if (image_width == '0) begin
      eff_w_wide = 32'd1;
    end else if (width_ext > 32'(MAX_WIDTH)) begin
      eff_w_wide = 32'(MAX_WIDTH);
    end else begin
      eff_w_wide = width_ext;
    end
    eff_w = eff_w_wide[EW-1:0];
    eff_h = (image_height == '0) ? CFG_W'(1) : image_height;
  end

  // Handshake between the channels and the memory stage.
  assign s1_fire        = s1_valid && (!s1_emit || !out_valid || result_out.ready);
  assign pixel_in.ready = !s1_valid || s1_fire;
  assign accept         = pixel_in.valid && pixel_in.ready;
  assign pixel_phase    = {1'b0, in_row} < {{(ROW_W - CFG_W + 1){1'b0}}, eff_h};
  assign drop           = (pixel_in.func == FUNC_FLUSH) && pixel_phase;
  assign live           = accept && !drop;

  // Position bookkeeping for the beat being taken.
  always_comb begin
    acc_x    = pixel_phase && (pixel_in.pixel_value == PIXEL_SET);
    acc_emit = (in_row >= ROW_W'(2)) || ((in_row == ROW_W'(1)) && (in_column != '0));

    use_left  = out_col != '0;
    use_right = (32'(out_col) + 32'd1) < 32'(eff_w);
    use_above = out_row != '0;
    use_below = (32'(out_row) + 32'd1) < 32'(eff_h);
    acc_last  = !use_right && !use_below;

    // Bit 3*age+row: age 0,1,2 is right, center, left column;
    // row 0,1,2 is below, center, above.
    for (int k = 0; k < 9; k++) begin
      acc_mask[k] = ((k / 3 != 0) || use_right) && ((k / 3 != 2) || use_left) &&
                    ((k % 3 != 0) || use_below) && ((k % 3 != 2) || use_above);
    end

    in_column_next = in_column;
    in_row_next    = in_row;
    out_col_next   = out_col;
    out_row_next   = out_row;
    if (live) begin
      if ((32'(in_column) + 32'd1) >= 32'(eff_w)) begin
        in_column_next = '0;
        if (in_row != '1) begin
          in_row_next = in_row + 1'b1;
        end
      end else begin
        in_column_next = in_column + 1'b1;
      end
      if (acc_emit) begin
        if (acc_last) begin
          in_column_next = '0;
          in_row_next    = '0;
          out_col_next   = '0;
          out_row_next   = '0;
        end else if (!use_right) begin
          out_col_next = '0;
          out_row_next = out_row + 1'b1;
        end else begin
          out_col_next = out_col + 1'b1;
        end
      end
    end
  end

  // Memory stage data: forwarded write when the same column was just written.
  always_comb begin
    rd_data   = fwd ? fwd_data : mem_q;
    wr_data   = {rd_data[0], s1_x};
    win_shift = {window_bits[5:0], rd_data[1], rd_data[0], s1_x};
    win_all   = &(win_shift | ~s1_mask);
    win_any   = |(win_shift & s1_mask);
  end

  // Line memory: read when a beat is taken, written back as it leaves.
  always_ff @(posedge clk) begin
    if (s1_fire) begin
      line_mem[s1_col] <= wr_data;
    end
    if (live) begin
      mem_q <= line_mem[in_column];
    end
  end

  // Control registers.
  always_ff @(posedge clk) begin
    if (rst) begin
      in_column   <= '0;
      in_row      <= '0;
      out_col     <= '0;
      out_row     <= '0;
      s1_valid    <= 1'b0;
      window_bits <= '0;
      out_valid   <= 1'b0;
    end else begin
      in_column <= in_column_next;
      in_row    <= in_row_next;
      out_col   <= out_col_next;
      out_row   <= out_row_next;
      if (live) begin
        s1_valid <= 1'b1;
      end else if (s1_fire) begin
        s1_valid <= 1'b0;
      end
      if (s1_fire) begin
        window_bits <= s1_last ? '0 : win_shift;
      end
      if (s1_fire && s1_emit) begin
        out_valid <= 1'b1;
      end else if (result_out.ready) begin
        out_valid <= 1'b0;
      end
    end
  end

  // Payload registers of the memory stage and the result.
  always_ff @(posedge clk) begin
    if (live) begin
      s1_x     <= acc_x;
      s1_emit  <= acc_emit;
      s1_last  <= acc_emit && acc_last;
      s1_mask  <= acc_mask;
      s1_col   <= in_column;
      fwd      <= s1_fire && (s1_col == in_column);
      fwd_data <= wr_data;
    end
    if (s1_fire && s1_emit) begin
      out_on  <= (op_mode == MODE_DILATION) ? win_any : win_all;
      out_end <= s1_last;
    end
  end

  assign result_out.valid     = out_valid;
  assign result_out.pixel_on  = out_on;
  assign result_out.frame_end = out_end;

  // Configuration port.
  assign pready    = 1'b1;
  assign cfg_write = psel && penable && pwrite && pready;

  always_ff @(posedge clk) begin
    if (rst) begin
      image_width  <= IMAGE_WIDTH_RST;
      image_height <= IMAGE_HEIGHT_RST;
      op_mode      <= MODE_EROSION;
    end else if (cfg_write) begin
      case (paddr[CFG_ADDR_W-1:2])
        REG_IMAGE_WIDTH:  image_width  <= pwdata[CFG_W-1:0];
        REG_IMAGE_HEIGHT: image_height <= pwdata[CFG_W-1:0];
        REG_OP_MODE:      op_mode      <= pwdata[0];
        default: begin
        end
      endcase
    end
  end

  always_comb begin
    case (paddr[CFG_ADDR_W-1:2])
      REG_IMAGE_WIDTH:  prdata = CFG_DATA_W'(image_width);
      REG_IMAGE_HEIGHT: prdata = CFG_DATA_W'(image_height);
      REG_OP_MODE:      prdata = CFG_DATA_W'(op_mode);
      default:          prdata = '0;
    endcase
  end

  // A result waiting on a stalled output must block new beats.
  `BM3_ASSERT_NOW(a_stall_blocks_input, s1_valid && s1_emit && out_valid && !result_out.ready, !pixel_in.ready, "input taken while result stage is blocked")
  // A finished frame leaves all position counters at the origin.
  `BM3_ASSERT_NEXT(a_frame_restart, live && acc_emit && acc_last, in_column == '0 && in_row == '0 && out_col == '0 && out_row == '0, "counters not cleared after frame end")
  // Every emitting beat leaving the memory stage lands in the result register.
  `BM3_ASSERT_NEXT(a_result_loaded, s1_fire && s1_emit, out_valid, "result lost after memory stage")

endmodule

[tb/bm3_morph_checker.sv]
// Checker that predicts the morphology result stream and compares every result beat.
module bm3_morph_checker (
  input  logic                           clk,
  input  logic                           rst,
  bm3_pixel_if                           pix,
  bm3_result_if                          res,
  input  logic                           psel,
  input  logic                           penable,
  input  logic                           pwrite,
  input  logic [bm3_pkg::CFG_ADDR_W-1:0] paddr,
  input  logic [bm3_pkg::CFG_DATA_W-1:0] pwdata,
  input  logic                           pready,
  output int                             errors,
  output int                             pending
);
  import bm3_pkg::*;

  typedef struct packed {
    logic pixel_on;
    logic frame_end;
  } morph_px_t;

  localparam int unsigned LINE_LEN   = DEF_MAX_WIDTH;

  // Shadow copies of the registers.
  logic [CFG_W-1:0] width_reg;
  logic [CFG_W-1:0] height_reg;
  logic             mode_reg;

  // Two one-line delays of the binarized stream and the 3x3 window.
  bit               line_back1 [LINE_LEN];
  bit               line_back2 [LINE_LEN];
  logic [8:0]       win_bits;
  int unsigned      col_pos;
  int unsigned      row_pos;
  int unsigned      out_pos;

  morph_px_t        due_pixels [$];
  int               fail_count = 0;

  function automatic int unsigned eff_width();
    if (width_reg == 0) return 1;
    if (width_reg > LINE_LEN) return LINE_LEN;
    return width_reg;
  endfunction

  function automatic int unsigned eff_height();
    return (height_reg == 0) ? 1 : height_reg;
  endfunction

  function automatic void restart_frame();
    win_bits = '0;
    col_pos  = 0;
    row_pos  = 0;
    out_pos  = 0;
  endfunction

  // Push one accepted input beat through the delay lines and, when it releases
  // a result, work out the erosion or dilation of the position it completes.
  task automatic take_beat(input logic kind, input logic [PIXEL_W-1:0] value);
    int unsigned w, h, slot, r, c;
    int          age, lane, dc, dr;
    bit          feeding, emit, x, a, b, all_set, any_set, last;
    morph_px_t   want;
    w = eff_width();
    h = eff_height();
    feeding = (row_pos < h);
    // A flush while pixels are still due is dropped without any effect.
    if (kind == FUNC_FLUSH && feeding) return;
    x = feeding && (value == PIXEL_SET);
    emit = (row_pos >= 2) || (row_pos == 1 && col_pos >= 1);

    slot = (col_pos < LINE_LEN) ? col_pos : 0;
    a = line_back1[slot];
    b = line_back2[slot];
    line_back2[slot] = a;
    line_back1[slot] = x;
    win_bits = {win_bits[5:0], b, a, x};

    if (col_pos + 1 >= w) begin
      col_pos = 0;
      if (row_pos < 32'hFFFF) row_pos++;
    end else begin
      col_pos++;
    end

    if (!emit) return;

    // Window bit 3*age+lane: age 0..2 is column c+1..c-1, lane 0..2 is row r+1..r-1.
    r = out_pos / w;
    c = out_pos % w;
    all_set = 1'b1;
    any_set = 1'b0;
    for (age = 0; age < 3; age++) begin
      dc = 1 - age;
      if ((dc < 0 && c == 0) || (dc > 0 && c + 1 >= w)) continue;
      for (lane = 0; lane < 3; lane++) begin
        dr = 1 - lane;
        if ((dr < 0 && r == 0) || (dr > 0 && r + 1 >= h)) continue;
        all_set &= win_bits[3*age + lane];
        any_set |= win_bits[3*age + lane];
      end
    end
    last = (out_pos + 1 >= w * h);
    want.pixel_on  = (mode_reg == MODE_DILATION) ? any_set : all_set;
    want.frame_end = last;
    due_pixels.push_back(want);

    if (last) restart_frame();
    else out_pos = (out_pos + 1) & 32'hFFFFFF;
  endtask

  always @(posedge clk) begin
    morph_px_t want;
    if (rst) begin
      width_reg  = IMAGE_WIDTH_RST;
      height_reg = IMAGE_HEIGHT_RST;
      mode_reg   = MODE_EROSION;
      foreach (line_back1[i]) begin
        line_back1[i] = 1'b0;
        line_back2[i] = 1'b0;
      end
      restart_frame();
      due_pixels.delete();
    end else begin
      // Register writes land on the access cycle.
      if (psel && penable && pwrite && pready) begin
        case (paddr[CFG_ADDR_W-1:2])
          REG_IMAGE_WIDTH:  width_reg  = pwdata[CFG_W-1:0];
          REG_IMAGE_HEIGHT: height_reg = pwdata[CFG_W-1:0];
          REG_OP_MODE:      mode_reg   = pwdata[0];
          default: ;
        endcase
      end

      // Compare before predicting, so a new expectation never meets this beat.
      if (res.valid && res.ready) begin
        if (due_pixels.size() == 0) begin
          fail_count++;
          $display("%0t: result beat with none expected: expected nothing, got on=%0b end=%0b",
                   $time, res.pixel_on, res.frame_end);
        end else begin
          want = due_pixels.pop_front();
          if (res.pixel_on !== want.pixel_on) begin
            fail_count++;
            $display("%0t: pixel_on mismatch: expected %0b, got %0b",
                     $time, want.pixel_on, res.pixel_on);
          end
          if (res.frame_end !== want.frame_end) begin
            fail_count++;
            $display("%0t: frame_end mismatch: expected %0b, got %0b",
                     $time, want.frame_end, res.frame_end);
          end
        end
      end

      if (pix.valid && pix.ready) take_beat(pix.func, pix.pixel_value);
    end
    errors  <= fail_count;
    pending <= due_pixels.size();
  end

endmodule

[tb/tb.sv]
// Testbench top: clock, reset, register setup, pixel stimulus and the verdict.
module tb;
  import bm3_pkg::*;

  typedef logic [PIXEL_W-1:0] pix_queue_t [$];

  localparam int unsigned RANDOM_ITEMS = 1700;
  localparam int unsigned HEIGHT_LIMIT = 1 << CFG_W;

  logic                  clk = 1'b0;
  logic                  rst;
  logic                  psel;
  logic                  penable;
  logic                  pwrite;
  logic [CFG_ADDR_W-1:0] paddr;
  logic [CFG_DATA_W-1:0] pwdata;
  logic [CFG_DATA_W-1:0] prdata;
  logic                  pready;
  int                    errors;
  int                    pending;
  bit                    calm;
  int unsigned           sent_items;

  bm3_pixel_if  pixel_ch ();
  bm3_result_if result_ch ();

  binary_morphology_3x3_unit uut (
    .clk        (clk),
    .rst        (rst),
    .pixel_in   (pixel_ch),
    .result_out (result_ch),
    .psel       (psel),
    .penable    (penable),
    .pwrite     (pwrite),
    .paddr      (paddr),
    .pwdata     (pwdata),
    .prdata     (prdata),
    .pready     (pready)
  );

  bm3_morph_checker chk (
    .clk     (clk),
    .rst     (rst),
    .pix     (pixel_ch),
    .res     (result_ch),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .pready  (pready),
    .errors  (errors),
    .pending (pending)
  );

  always #10 clk = ~clk;

  // Hard stop in case the block hangs or drops results.
  initial begin
    #4_000_000;
    $display("** binary_morphology_3x3_unit: FAILED **");
    $finish;
  end

  // Idle length: mostly none or short, now and then long; none in calm stretches.
  function automatic int pick_gap();
    int roll;
    if (calm) return 0;
    roll = $urandom_range(0, 99);
    if (roll < 65) return 0;
    if (roll < 92) return $urandom_range(1, 3);
    if (roll < 99) return $urandom_range(4, 12);
    return $urandom_range(20, 60);
  endfunction

  function automatic int unsigned dim_eff(input logic [CFG_W-1:0] v, input int unsigned hi);
    if (v == 0) return 1;
    if (v > hi) return hi;
    return v;
  endfunction

  // Random frame content; dens is the percentage of fully set pixels.
  function automatic pix_queue_t fill_frame(input int unsigned n, input int dens);
    pix_queue_t q;
    for (int unsigned i = 0; i < n; i++) begin
      if ($urandom_range(0, 99) < dens) q.push_back(PIXEL_SET);
      else begin
        case ($urandom_range(0, 3))
          0:       q.push_back(8'd0);
          1:       q.push_back(8'd254);
          default: q.push_back(8'($urandom_range(0, 254)));
        endcase
      end
    end
    return q;
  endfunction

  // Result side: ready drops for random stretches.
  initial begin : result_stall
    int hold;
    result_ch.ready <= 1'b0;
    @(posedge clk);
    while (rst) @(posedge clk);
    forever begin
      hold = pick_gap();
      if (hold > 0) begin
        result_ch.ready <= 1'b0;
        repeat (hold) @(posedge clk);
      end
      result_ch.ready <= 1'b1;
      repeat ($urandom_range(1, 16)) @(posedge clk);
    end
  end

  task automatic send_beat(input logic kind, input logic [PIXEL_W-1:0] value);
    int gap;
    gap = pick_gap();
    if (gap > 0) begin
      pixel_ch.valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    pixel_ch.valid       <= 1'b1;
    pixel_ch.func        <= kind;
    pixel_ch.pixel_value <= value;
    @(posedge clk);
    while (!pixel_ch.ready) @(posedge clk);
  endtask

  // Hold the sender until every predicted result has come back, then let the
  // pipeline settle so ignored flush beats have left it too.
  task automatic wait_drained();
    pixel_ch.valid <= 1'b0;
    @(posedge clk);
    while (pending != 0) @(posedge clk);
    repeat (8) @(posedge clk);
  endtask

  task automatic cfg_write(input logic [REG_IDX_W-1:0] idx, input logic [CFG_DATA_W-1:0] value);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= {idx, 2'b00};
    pwdata  <= value;
    @(posedge clk);
    penable <= 1'b1;
    @(posedge clk);
    while (!pready) @(posedge clk);
  endtask

  // One whole frame: registers, pixels with optional stray beats, then the drain.
  // stray forces an ignored flush before the first two pixels and makes the
  // first drain beat a pixel item whose value must be ignored.
  task automatic play_frame(input logic [CFG_W-1:0] w_reg, input logic [CFG_W-1:0] h_reg,
                            input logic mode, input pix_queue_t pix_q, input int noise_pct,
                            input bit stray, input int hold_at);
    int unsigned w_eff;
    w_eff = dim_eff(w_reg, DEF_MAX_WIDTH);
    cfg_write(REG_IMAGE_WIDTH, CFG_DATA_W'(w_reg));
    cfg_write(REG_IMAGE_HEIGHT, CFG_DATA_W'(h_reg));
    cfg_write(REG_OP_MODE, CFG_DATA_W'(mode));
    psel    <= 1'b0;
    penable <= 1'b0;
    pwrite  <= 1'b0;
    foreach (pix_q[i]) begin
      if (i == hold_at) wait_drained();
      if ($urandom_range(0, 99) < noise_pct || (stray && i < 2))
        send_beat(FUNC_FLUSH, 8'($urandom));
      send_beat(FUNC_PIXEL, pix_q[i]);
      sent_items++;
    end
    for (int unsigned j = 0; j <= w_eff; j++) begin
      if ($urandom_range(0, 99) < 3 * noise_pct || (stray && j == 0))
        send_beat(FUNC_PIXEL, 8'($urandom));
      else
        send_beat(FUNC_FLUSH, 8'($urandom));
      sent_items++;
    end
    wait_drained();
  endtask

  initial begin : stimulus
    pix_queue_t  pix_q;
    int unsigned w, h, start;
    int          dens;
    rst                  <= 1'b1;
    psel                 <= 1'b0;
    penable              <= 1'b0;
    pwrite               <= 1'b0;
    paddr                <= '0;
    pwdata               <= '0;
    pixel_ch.valid       <= 1'b0;
    pixel_ch.func        <= FUNC_PIXEL;
    pixel_ch.pixel_value <= '0;
    calm       = 1'b0;
    sent_items = 0;
    repeat (11) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // Directed: a 3x3 erosion with one near-white corner and stray beats,
    // a zero-size frame that acts as 1x1, and a lone set pixel under dilation.
    pix_q = '{PIXEL_SET, PIXEL_SET, PIXEL_SET, PIXEL_SET, PIXEL_SET,
              PIXEL_SET, PIXEL_SET, PIXEL_SET, 8'd254};
    play_frame(11'd3, 11'd3, MODE_EROSION, pix_q, 0, 1'b1, -1);
    pix_q = '{PIXEL_SET};
    play_frame(11'd0, 11'd0, MODE_EROSION, pix_q, 0, 1'b0, -1);
    pix_q = '{8'd0, 8'd0, 8'd0, 8'd0, PIXEL_SET, 8'd0};
    play_frame(11'd3, 11'd2, MODE_DILATION, pix_q, 0, 1'b0, -1);

    // Random frames, mostly small, with varied density and stall behavior.
    start = sent_items;
    while (sent_items - start < RANDOM_ITEMS) begin
      if ($urandom_range(0, 9) == 0) begin
        w = $urandom_range(25, 120);
        h = $urandom_range(1, 6);
      end else begin
        w = $urandom_range(1, 24);
        h = $urandom_range(1, 12);
      end
      if ($urandom_range(0, 19) == 0) w = 0;
      if ($urandom_range(0, 19) == 0) h = 0;
      case ($urandom_range(0, 4))
        0:       dens = 5;
        1:       dens = 50;
        2:       dens = 85;
        3:       dens = 97;
        default: dens = 100;
      endcase
      pix_q = fill_frame(dim_eff(CFG_W'(w), DEF_MAX_WIDTH) * dim_eff(CFG_W'(h), HEIGHT_LIMIT),
                         dens);
      calm = ($urandom_range(0, 4) == 0);
      play_frame(CFG_W'(w), CFG_W'(h), logic'($urandom_range(0, 1)), pix_q,
                 ($urandom_range(0, 2) == 0) ? 8 : 0, 1'b0,
                 ($urandom_range(0, 5) == 0) ? int'(pix_q.size() / 2) : -1);
    end

    repeat (10) @(posedge clk);
    if (errors == 0) begin
      $display("** binary_morphology_3x3_unit: PASSED **");
    end else begin
      $display("** binary_morphology_3x3_unit: FAILED **");
    end
    $finish;
  end

endmodule
